// ===== design/glcd_spw_pkg.sv =====
// Shared types and constants for the GLCD shadow pixel writer.
// No dependencies; used by every module of the block.
package glcd_spw_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int ROWS_DEF    = 64;
    localparam int PAGES_DEF   = 8;

    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [7:0] COL_HIGH_CMD  = 8'h10;
    localparam logic [7:0] HIGH_NIBBLE   = 8'hF0;
    localparam logic [7:0] LOW_NIBBLE    = 8'h0F;

    typedef enum logic {
        ST_IDLE,
        ST_MODIFY
    } state_t;

    typedef enum logic [2:0] {
        STEP_GO_PAGE,
        STEP_GO_COL_HI,
        STEP_GO_COL_LO,
        STEP_DATA,
        STEP_WRAP_PAGE,
        STEP_WRAP_COL_HI,
        STEP_WRAP_COL_LO
    } step_t;

    typedef struct packed {
        step_t      first;
        step_t      last;
        logic [3:0] page;
        logic [7:0] col;
        logic [7:0] data;
        logic [3:0] wrap_page;
    } emit_job_t;

endpackage

// ===== design/glcd_spw_shadow_mem.sv =====
// Shadow frame buffer: one byte per page and column, registered read.
// Sweeps the whole array to zero after reset. Uses glcd_spw_pkg.
module glcd_spw_shadow_mem #(
    parameter int DEPTH = glcd_spw_pkg::PAGES_DEF * glcd_spw_pkg::COLUMNS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    output logic          clear_busy
);
    import glcd_spw_pkg::*;

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic          clearing_reg;
    logic          clearing_next;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        we    = clearing_reg | wr_en;
        waddr = clearing_reg ? clr_addr_reg : wr_addr;
        wdata = clearing_reg ? 8'h00 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign clear_busy = clearing_reg;

endmodule

// ===== design/glcd_spw_emit.sv =====
// Byte sequencer: turns one job into goto, data and wrap bytes, one per
// cycle while the output is not stalled, into an output register. Uses glcd_spw_pkg.
module glcd_spw_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  glcd_spw_pkg::emit_job_t job,
    output logic                   busy,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] bus_byte
    output logic                   m_tuser,   // [0] is_command
    output logic                   m_tlast
);
    import glcd_spw_pkg::*;

    emit_job_t  job_reg;
    emit_job_t  job_next;
    step_t      step_reg;
    step_t      step_next;
    logic       active_reg;
    logic       active_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       cmd_reg;
    logic       cmd_next;
    logic       last_reg;
    logic       last_next;
    logic       load;
    logic [7:0] sel_byte;
    logic       sel_cmd;

    always_comb
    begin
        sel_byte = job_reg.data;
        sel_cmd  = 1'b1;
        unique case (step_reg)
            STEP_GO_PAGE:     sel_byte = PAGE_CMD_BASE + {4'b0000, job_reg.page};
            STEP_GO_COL_HI:   sel_byte = ((job_reg.col & HIGH_NIBBLE) >> 4) | COL_HIGH_CMD;
            STEP_GO_COL_LO:   sel_byte = job_reg.col & LOW_NIBBLE;
            STEP_DATA:
            begin
                sel_byte = job_reg.data;
                sel_cmd  = 1'b0;
            end
            STEP_WRAP_PAGE:   sel_byte = PAGE_CMD_BASE + {4'b0000, job_reg.wrap_page};
            STEP_WRAP_COL_HI: sel_byte = COL_HIGH_CMD;
            STEP_WRAP_COL_LO: sel_byte = 8'h00;
            default:          sel_byte = job_reg.data;
        endcase
    end

    always_comb
    begin
        job_next    = job_reg;
        step_next   = step_reg;
        active_next = active_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        cmd_next    = cmd_reg;
        last_next   = last_reg;
        load        = active_reg && (!valid_reg || m_tready);

        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = sel_byte;
            cmd_next   = sel_cmd;
            last_next  = (step_reg == job_reg.last);
            step_next  = step_t'(step_reg + 3'd1);
            if (step_reg == job_reg.last)
            begin
                active_next = 1'b0;
            end
        end
        if (start)
        begin
            job_next    = job;
            step_next   = job.first;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            step_reg   <= STEP_GO_PAGE;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        byte_reg <= byte_next;
        cmd_reg  <= cmd_next;
        last_reg <= last_next;
    end

    assign busy     = active_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = cmd_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== design/glcd_shadow_pixel_writer.sv =====
// Top level of the GLCD shadow pixel writer: item decode, cursor and
// read-modify-write control. Uses glcd_spw_pkg, glcd_spw_shadow_mem, glcd_spw_emit.
//
// Accepts column-byte writes (tuser 0) and single-pixel set/clear items (tuser 1)
// and emits the controller byte stream: an optional goto (page, column-high,
// column-low), the data byte, and a wrap goto at the end of a line; tlast marks
// the final byte of each item. An in-range item passes a shadow read, then a
// modify and write back, then its emitted bytes; an out-of-range item is dropped.
// The byte sequencer emits one byte per cycle while the output is not stalled and
// sets the rate. After reset the shadow buffer is swept to zero, while s_tready
// stays low.
module glcd_shadow_pixel_writer #(
    parameter int COLUMNS = glcd_spw_pkg::COLUMNS_DEF,
    parameter int ROWS    = glcd_spw_pkg::ROWS_DEF,
    parameter int PAGES   = glcd_spw_pkg::PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [5:0] row, [12:6] col, [20:13] data, [21] pixel_on
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] bus_byte
    output logic        m_tuser,   // [0] is_command
    output logic        m_tlast
);
    import glcd_spw_pkg::*;

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CRW   = $clog2(ROWS);
    localparam int CCW   = $clog2(COLUMNS);
    localparam int RCW   = (CRW > 6) ? CRW : 6;
    localparam int CCMP  = (CCW > 7) ? CCW : 7;

    state_t         state_reg;
    state_t         state_next;
    logic [CRW-1:0] cur_row_reg;
    logic [CRW-1:0] cur_row_next;
    logic [CCW-1:0] cur_col_reg;
    logic [CCW-1:0] cur_col_next;
    logic           op_reg;
    logic [5:0]     row_reg;
    logic [6:0]     col_reg;
    logic [7:0]     data_reg;
    logic           pixel_reg;
    logic [AW-1:0]  addr_reg;

    logic           accept;
    logic           in_op;
    logic [5:0]     in_row;
    logic [6:0]     in_col;
    logic [7:0]     in_data;
    logic           in_pixel;
    logic           in_range;
    logic [AW-1:0]  in_addr;

    logic [7:0]     rd_data;
    logic           clear_busy;
    logic           emit_busy;
    logic           mem_rd;
    logic           mem_wr;
    logic [7:0]     new_byte;
    logic [7:0]     bit_mask;
    logic           match;
    logic [CRW-1:0] trow;
    logic [CCW-1:0] tcol;
    logic [CRW-1:0] nrow;
    logic           line_end;
    logic           start;
    emit_job_t      job;

    assign in_op    = s_tuser;
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[12:6];
    assign in_data  = s_tdata[20:13];
    assign in_pixel = s_tdata[21];

    assign s_tready = (state_reg == ST_IDLE) && !clear_busy && !emit_busy;
    assign accept   = s_tvalid && s_tready;
    assign in_range = (int'(in_row) < ROWS) && (int'(in_col) < COLUMNS)
                      && (int'(in_row[5:3]) < PAGES);
    assign in_addr  = AW'(in_row[5:3]) * AW'(COLUMNS) + AW'(in_col);

    always_comb
    begin
        state_next   = state_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        mem_rd       = 1'b0;
        mem_wr       = 1'b0;
        start        = 1'b0;

        bit_mask = 8'h01 << row_reg[2:0];
        if (op_reg)
        begin
            new_byte = pixel_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        end
        else
        begin
            new_byte = data_reg;
        end

        match    = (RCW'(row_reg) == RCW'(cur_row_reg))
                   && (CCMP'(col_reg) == CCMP'(cur_col_reg));
        trow     = CRW'(row_reg);
        tcol     = CCW'(col_reg);
        line_end = (tcol == CCW'(COLUMNS - 1));
        nrow     = (trow == CRW'(ROWS - 1)) ? '0 : trow + CRW'(1);

        job.first     = match ? STEP_DATA : STEP_GO_PAGE;
        job.last      = line_end ? STEP_WRAP_COL_LO : STEP_DATA;
        job.page      = 4'(row_reg[5:3]);
        job.col       = 8'(col_reg);
        job.data      = new_byte;
        job.wrap_page = 4'(nrow >> 3);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range)
                begin
                    mem_rd     = 1'b1;
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                mem_wr     = 1'b1;
                start      = 1'b1;
                state_next = ST_IDLE;
                if (line_end)
                begin
                    cur_col_next = '0;
                    cur_row_next = nrow;
                end
                else
                begin
                    cur_col_next = tcol + CCW'(1);
                    cur_row_next = trow;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            row_reg   <= in_row;
            col_reg   <= in_col;
            data_reg  <= in_data;
            pixel_reg <= in_pixel;
            addr_reg  <= in_addr;
        end
    end

    glcd_spw_shadow_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (mem_rd),
        .rd_addr    (in_addr),
        .rd_data    (rd_data),
        .wr_en      (mem_wr),
        .wr_addr    (addr_reg),
        .wr_data    (new_byte),
        .clear_busy (clear_busy)
    );

    glcd_spw_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .job      (job),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
